/* src/bdc_pkg.sv */
// Shared types and constants for the button debounce and click classifier.
package bdc_pkg;

  localparam int TIME_BITS_DEFAULT = 32;

  localparam int NOW_W = 32;
  localparam int CFG_W = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd25;
  localparam logic [CFG_W-1:0] DOUBLE_GAP_RESET = 16'd350;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_GAP = 2'd1;

  localparam logic [1:0] CLICKS_DOUBLE = 2'd2;
  localparam logic [1:0] CLICKS_ONE = 2'd1;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic       debounced_down;
    logic       holds_tone;
    logic [1:0] click_count;
  } flags_t;

  typedef struct packed {
    event_kind_t kind;
    logic        tone_start;
    logic        tone_stop;
    logic        key_down;
  } result_t;

endpackage

/* src/button_debounce_click_classifier.sv */
// Top level of the button debounce and single/double click classifier.
// A beat accepted into the input register moves on to the result register when the output does not stall.
// Throughput: one beat per cycle while the output is not stalled; the input and result registers stall together.
// The block state is updated as a sample moves from the input to the result register.
// Reset clears all key state, the click count and both time marks,
// and loads debounce 25 ms and double-click gap 350 ms.
module button_debounce_click_classifier #(
  parameter int TIME_BITS = bdc_pkg::TIME_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bdc_pkg::NOW_W-1:0]       now_ms,
  input  logic                            raw_down,
  input  logic                            tone_free,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      event_kind,
  output logic [bdc_pkg::NOW_W-1:0]       event_time_ms,
  output logic                            tone_start,
  output logic                            tone_stop,
  output logic                            key_down,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bdc_pkg::CFG_W-1:0]       cfg_data
);

  logic [bdc_pkg::CFG_W-1:0] debounce_time;
  logic [bdc_pkg::CFG_W-1:0] click_gap;

  logic                      s1_valid;
  logic [bdc_pkg::NOW_W-1:0] s1_now;
  logic                      s1_raw;
  logic                      s1_free;

  bdc_pkg::flags_t      flags;
  bdc_pkg::flags_t      flags_next;
  logic [TIME_BITS-1:0] last_edge_time;
  logic [TIME_BITS-1:0] last_edge_time_next;
  logic [TIME_BITS-1:0] last_release_time;
  logic [TIME_BITS-1:0] last_release_time_next;

  bdc_pkg::result_t     step_result;
  bdc_pkg::result_t     result;
  logic [bdc_pkg::NOW_W-1:0] result_time;

  logic advance;
  logic fire;

  assign advance = !out_valid || !out_stall;
  assign fire = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign cfg_ready = 1'b1;

  bdc_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .now                   (TIME_BITS'(s1_now)),
    .raw_down              (s1_raw),
    .tone_free             (s1_free),
    .debounce_time         (debounce_time),
    .click_gap             (click_gap),
    .flags                 (flags),
    .last_edge_time        (last_edge_time),
    .last_release_time     (last_release_time),
    .flags_next            (flags_next),
    .last_edge_time_next   (last_edge_time_next),
    .last_release_time_next(last_release_time_next),
    .result                (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= bdc_pkg::DEBOUNCE_RESET;
      click_gap <= bdc_pkg::DOUBLE_GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bdc_pkg::REG_DEBOUNCE) begin
        debounce_time <= cfg_data;
      end else if (cfg_index == bdc_pkg::REG_DOUBLE_GAP) begin
        click_gap <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_now <= now_ms;
      s1_raw <= raw_down;
      s1_free <= tone_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      last_edge_time <= '0;
      last_release_time <= '0;
    end else if (fire) begin
      flags <= flags_next;
      last_edge_time <= last_edge_time_next;
      last_release_time <= last_release_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (fire) begin
      result <= step_result;
      result_time <= s1_now;
    end
  end

  assign event_kind = result.kind;
  assign event_time_ms = result_time;
  assign tone_start = result.tone_start;
  assign tone_stop = result.tone_stop;
  assign key_down = result.key_down;

endmodule

/* src/bdc_step.sv */
// Next-state and result logic for one poll sample of the click classifier.
module bdc_step #(
  parameter int TIME_BITS = bdc_pkg::TIME_BITS_DEFAULT
) (
  input  logic [TIME_BITS-1:0]     now,
  input  logic                     raw_down,
  input  logic                     tone_free,
  input  logic [bdc_pkg::CFG_W-1:0] debounce_time,
  input  logic [bdc_pkg::CFG_W-1:0] click_gap,
  input  bdc_pkg::flags_t          flags,
  input  logic [TIME_BITS-1:0]     last_edge_time,
  input  logic [TIME_BITS-1:0]     last_release_time,
  output bdc_pkg::flags_t          flags_next,
  output logic [TIME_BITS-1:0]     last_edge_time_next,
  output logic [TIME_BITS-1:0]     last_release_time_next,
  output bdc_pkg::result_t         result
);

  logic [TIME_BITS-1:0] edge_elapsed;
  logic [TIME_BITS-1:0] release_elapsed;
  logic                 edge_ok;

  assign edge_elapsed = now - last_edge_time;
  assign edge_ok = (raw_down != flags.debounced_down) &&
                   (edge_elapsed >= TIME_BITS'(debounce_time));

  always_comb begin
    flags_next = flags;
    last_edge_time_next = last_edge_time;
    last_release_time_next = last_release_time;
    result.kind = bdc_pkg::EV_NONE;
    result.tone_start = 1'b0;
    result.tone_stop = 1'b0;
    if (edge_ok) begin
      flags_next.debounced_down = raw_down;
      last_edge_time_next = now;
      if (raw_down) begin
        flags_next.holds_tone = tone_free;
        result.tone_start = tone_free;
      end else begin
        if (flags.holds_tone) begin
          result.tone_stop = 1'b1;
          flags_next.holds_tone = 1'b0;
        end
        last_release_time_next = now;
        flags_next.click_count = flags.click_count + 2'd1;
        if (flags_next.click_count >= bdc_pkg::CLICKS_DOUBLE) begin
          result.kind = bdc_pkg::EV_DOUBLE;
          flags_next.click_count = '0;
        end
      end
    end
    release_elapsed = now - last_release_time_next;
    if (flags_next.click_count == bdc_pkg::CLICKS_ONE && !flags_next.debounced_down &&
        release_elapsed >= TIME_BITS'(click_gap)) begin
      result.kind = bdc_pkg::EV_SINGLE;
      flags_next.click_count = '0;
    end
    result.key_down = flags_next.debounced_down;
  end

endmodule

/* tb/button_debounce_click_classifier_tb.sv */
// Self-checking testbench for the button debounce and single/double click classifier.
module button_debounce_click_classifier_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 100;

  typedef struct {
    bdc_pkg::event_kind_t      kind;
    logic [bdc_pkg::NOW_W-1:0] time_ms;
    logic                      start;
    logic                      stop;
    logic                      key_down;
  } click_beat_t;

  class click_tracker;
    logic [bdc_pkg::CFG_W-1:0] debounce_time;
    logic [bdc_pkg::CFG_W-1:0] click_gap;
    logic                      key_is_down;
    logic                      holds_tone;
    logic [bdc_pkg::NOW_W-1:0] last_edge_ms;
    logic [bdc_pkg::NOW_W-1:0] last_release_ms;
    logic [1:0]                clicks;
    click_beat_t               due_events[$];
    int unsigned               errors;
    int unsigned               results;
    int unsigned               singles;
    int unsigned               doubles;
    int unsigned               starts;
    int unsigned               stops;

    function new();
      debounce_time = bdc_pkg::DEBOUNCE_RESET;
      click_gap = bdc_pkg::DOUBLE_GAP_RESET;
      key_is_down = 1'b0;
      holds_tone = 1'b0;
      last_edge_ms = '0;
      last_release_ms = '0;
      clicks = '0;
      errors = 0;
      results = 0;
      singles = 0;
      doubles = 0;
      starts = 0;
      stops = 0;
    endfunction

    function void set_register(logic [bdc_pkg::CFG_INDEX_W-1:0] index,
                               logic [bdc_pkg::CFG_W-1:0] value);
      if (index == bdc_pkg::REG_DEBOUNCE) begin
        debounce_time = value;
      end else if (index == bdc_pkg::REG_DOUBLE_GAP) begin
        click_gap = value;
      end
    endfunction

    function int unsigned pending();
      return due_events.size();
    endfunction

    function void note_sample(logic [bdc_pkg::NOW_W-1:0] now, logic raw, logic tone_ok);
      click_beat_t e;
      logic [bdc_pkg::NOW_W-1:0] since_edge;
      logic [bdc_pkg::NOW_W-1:0] since_release;
      e.kind = bdc_pkg::EV_NONE;
      e.time_ms = now;
      e.start = 1'b0;
      e.stop = 1'b0;
      since_edge = now - last_edge_ms;
      if (raw != key_is_down && since_edge >= {16'd0, debounce_time}) begin
        key_is_down = raw;
        last_edge_ms = now;
        if (raw) begin
          holds_tone = tone_ok;
          e.start = tone_ok;
        end else begin
          if (holds_tone) begin
            e.stop = 1'b1;
            holds_tone = 1'b0;
          end
          last_release_ms = now;
          clicks = clicks + 2'd1;
          if (clicks >= bdc_pkg::CLICKS_DOUBLE) begin
            e.kind = bdc_pkg::EV_DOUBLE;
            clicks = '0;
          end
        end
      end
      since_release = now - last_release_ms;
      if (clicks == bdc_pkg::CLICKS_ONE && !key_is_down &&
          since_release >= {16'd0, click_gap}) begin
        e.kind = bdc_pkg::EV_SINGLE;
        clicks = '0;
      end
      e.key_down = key_is_down;
      due_events.push_back(e);
    endfunction

    function void compare(string field, logic [bdc_pkg::NOW_W-1:0] want,
                          logic [bdc_pkg::NOW_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_event(logic [1:0] kind, logic [bdc_pkg::NOW_W-1:0] t, logic start,
                              logic stop, logic down);
      click_beat_t want;
      if (due_events.size() == 0) begin
        $display("%0t: result beat with nothing outstanding, kind %0d time %0h",
                 $time, kind, t);
        errors++;
        return;
      end
      want = due_events.pop_front();
      results++;
      if (want.kind == bdc_pkg::EV_SINGLE) singles++;
      if (want.kind == bdc_pkg::EV_DOUBLE) doubles++;
      if (want.start) starts++;
      if (want.stop) stops++;
      compare("event_kind", 32'(want.kind), 32'(kind));
      compare("event_time_ms", want.time_ms, t);
      compare("tone_start", 32'(want.start), 32'(start));
      compare("tone_stop", 32'(want.stop), 32'(stop));
      compare("key_down", 32'(want.key_down), 32'(down));
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [bdc_pkg::NOW_W-1:0]       now_ms;
  logic                            raw_down;
  logic                            tone_free;
  logic                            out_valid;
  logic                            out_stall;
  logic [1:0]                      event_kind;
  logic [bdc_pkg::NOW_W-1:0]       event_time_ms;
  logic                            tone_start;
  logic                            tone_stop;
  logic                            key_down;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [bdc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bdc_pkg::CFG_W-1:0]       cfg_data;

  click_tracker tracker;
  int unsigned  quiet_cycles;
  int unsigned  tx_calm;
  int unsigned  rx_calm;
  int unsigned  settings_run;
  logic [bdc_pkg::NOW_W-1:0] gen_now;
  logic         gen_level;
  int unsigned  gen_hold;
  int unsigned  gen_bounce;

  button_debounce_click_classifier u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .now_ms        (now_ms),
    .raw_down      (raw_down),
    .tone_free     (tone_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind    (event_kind),
    .event_time_ms (event_time_ms),
    .tone_start    (tone_start),
    .tone_stop     (tone_stop),
    .key_down      (key_down),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned pick_wait(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 15);
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) tracker.note_sample(now_ms, raw_down, tone_free);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_event(event_kind, event_time_ms, tone_start, tone_stop, key_down);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timed out after %0d cycles without a beat", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver holds off twice for a long stretch so that the block fills and stalls its input.
  initial begin
    int unsigned beats;
    int unsigned wait_n;
    out_stall = 1'b0;
    beats = 0;
    rx_calm = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (beats == 60 || beats == 700) begin
        wait_n = HOLD_OFF_CYCLES;
      end else begin
        wait_n = pick_wait(rx_calm);
      end
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats++;
    end
  end

  task automatic send_sample(input logic [bdc_pkg::NOW_W-1:0] t, input logic raw,
                             input logic tone_ok);
    int unsigned gap;
    gap = pick_wait(tx_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    now_ms <= t;
    raw_down <= raw;
    tone_free <= tone_ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_settings(input logic [bdc_pkg::CFG_W-1:0] debounce,
                                input logic [bdc_pkg::CFG_W-1:0] gap);
    cfg_valid <= 1'b1;
    cfg_index <= bdc_pkg::REG_DEBOUNCE;
    cfg_data <= debounce;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_register(bdc_pkg::REG_DEBOUNCE, debounce);
    cfg_index <= bdc_pkg::REG_DOUBLE_GAP;
    cfg_data <= gap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_register(bdc_pkg::REG_DOUBLE_GAP, gap);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // Mostly press and release sequences with contact bounce, timed against the current settings,
  // mixed with samples at arbitrary times and levels.
  task automatic send_random(input int unsigned count);
    int unsigned deb;
    int unsigned gap;
    int unsigned step;
    logic        raw;
    deb = tracker.debounce_time;
    gap = tracker.click_gap;
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        gen_now = $urandom;
        raw = 1'($urandom_range(0, 1));
      end else begin
        if (gen_bounce != 0) begin
          step = $urandom_range(1, deb / 4 + 1);
        end else begin
          step = $urandom_range(1, (deb + gap) / 6 + 3);
        end
        gen_now = gen_now + step;
        if (step >= gen_hold) begin
          gen_level = !gen_level;
          gen_hold = gen_level ? $urandom_range(0, 2 * deb + 8)
                               : $urandom_range(0, 2 * gap + deb + 8);
          gen_bounce = $urandom_range(0, 3);
        end else begin
          gen_hold = gen_hold - step;
        end
        raw = (gen_bounce != 0) ? 1'($urandom_range(0, 1)) : gen_level;
        if (gen_bounce != 0) gen_bounce--;
      end
      send_sample(gen_now, raw, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    logic [bdc_pkg::CFG_W-1:0] deb;
    logic [bdc_pkg::CFG_W-1:0] gap;
    rst = 1'b1;
    in_valid = 1'b0;
    now_ms = '0;
    raw_down = 1'b0;
    tone_free = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = bdc_pkg::REG_DEBOUNCE;
    cfg_data = '0;
    tx_calm = 0;
    settings_run = 1;
    gen_level = 1'b0;
    gen_hold = 0;
    gen_bounce = 0;
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: early edge, bounce, single, busy tone, double and time wrap.
    send_sample(32'd10, 1'b1, 1'b1);
    send_sample(32'd30, 1'b1, 1'b1);
    send_sample(32'd40, 1'b0, 1'b1);
    send_sample(32'd60, 1'b0, 1'b1);
    send_sample(32'd100, 1'b0, 1'b1);
    send_sample(32'd420, 1'b0, 1'b1);
    send_sample(32'd500, 1'b1, 1'b0);
    send_sample(32'd600, 1'b0, 1'b1);
    send_sample(32'd650, 1'b1, 1'b1);
    send_sample(32'd700, 1'b0, 1'b1);
    send_sample(32'hFFFF_FFF0, 1'b1, 1'b1);
    send_sample(32'h0000_0010, 1'b0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
    send_sample(32'h0000_0000, 1'b1, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_sample(32'h8000_0000, 1'b1, 1'b0);
    gen_now = 32'h8000_0000;
    gen_level = 1'b1;
    send_random(200);
    settle();

    // No debounce and no gap: a lone release is classed as single at once.
    write_settings(16'd0, 16'd0);
    send_sample(32'd1000, 1'b1, 1'b1);
    send_sample(32'd1001, 1'b0, 1'b1);
    send_sample(32'd1001, 1'b1, 1'b0);
    send_sample(32'd1002, 1'b0, 1'b1);
    gen_now = 32'd1002;
    gen_level = 1'b0;
    send_random(150);
    settle();

    write_settings(16'hFFFF, 16'hFFFF);
    send_random(150);
    settle();

    repeat (4) begin
      deb = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(0, 60));
      gap = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(0, 600));
      write_settings(deb, gap);
      send_random(200);
      settle();
    end

    repeat (8) @(posedge clk);
    if (tracker.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, tracker.pending());
      tracker.errors++;
    end
    $display("Checked %0d results under %0d register settings.", tracker.results, settings_run);
    $display("Seen %0d single and %0d double clicks, %0d tone takes and %0d tone releases.",
             tracker.singles, tracker.doubles, tracker.starts, tracker.stops);
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
